### src/chs_pkg.sv
// chs_pkg: shared constants and codes for the coordinate hash set
// used by chs_hash and coordinate_hash_set_core; no dependencies
package chs_pkg;

    localparam int TABLE_BITS_DEF = 10;
    localparam int OCC_W          = 11;
    localparam int STATUS_W       = 3;
    localparam int COORD_W        = 32;
    localparam int HASH_W         = 64;

    localparam logic [HASH_W-1:0] HASH_OFFSET = 64'h8000_0000_8000_0000;
    localparam logic [HASH_W-1:0] HASH_MULT   = 64'd1111111111111111111;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_INSERTED = 3'd0,
        ST_PRESENT  = 3'd1,
        ST_REMOVED  = 3'd2,
        ST_ABSENT   = 3'd3,
        ST_FULL     = 3'd4
    } t_status;

endpackage

### src/coordinate_hash_set_core.sv
// coordinate_hash_set_core: open-addressing set of (x,y) points, double hashing
// steps: hash, then per probe a memory read and a compare, then the result; one probe per memory read
// one item at a time: a new item is taken only in idle, once the last result is handed on; the hash uses one multiplier
// reset: a clearing pass writes every slot to empty, not ready meanwhile
// depends on chs_pkg and chs_hash
module coordinate_hash_set_core import chs_pkg::*; #(
    parameter int TABLE_BITS = TABLE_BITS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic                      i_cmd,
    input  logic signed [COORD_W-1:0] i_point_x,
    input  logic signed [COORD_W-1:0] i_point_y,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [STATUS_W-1:0]       o_status,
    output logic [OCC_W-1:0]          o_occupancy
);

    localparam int TABLE_SIZE = 1 << TABLE_BITS;
    localparam int CNT_W = (TABLE_BITS + 1 > OCC_W) ? TABLE_BITS + 1 : OCC_W;

    typedef enum logic [5:0] {
        S_CLEAR = 6'b000001,
        S_IDLE  = 6'b000010,
        S_HASH  = 6'b000100,
        S_RD    = 6'b001000,
        S_CMP   = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state                r_state;
    t_state                n_state;
    logic [TABLE_BITS-1:0] r_clr_addr;
    logic                  r_cmd;
    logic [HASH_W-1:0]     r_hash;
    logic [TABLE_BITS-1:0] r_stride;
    logic [TABLE_BITS-1:0] r_pos;
    logic [TABLE_BITS-1:0] r_k;
    logic [HASH_W-1:0]     r_rdata;
    logic [CNT_W-1:0]      r_count;
    t_status               r_result;
    logic                  r_out_valid;
    logic [STATUS_W-1:0]   r_out_status;
    logic [OCC_W-1:0]      r_out_occ;
    logic [HASH_W-1:0]     r_mem [TABLE_SIZE];

    logic                  w_accept;
    logic [HASH_W-1:0]     w_hash;
    logic                  w_hash_done;
    logic [TABLE_BITS-1:0] w_stride;
    logic                  w_ins;
    logic                  w_empty;
    logic                  w_match;
    logic                  w_last;
    logic                  w_store;
    logic                  w_drop;
    logic                  w_finish;
    t_status               w_result;
    logic                  w_we;
    logic [TABLE_BITS-1:0] w_waddr;
    logic [HASH_W-1:0]     w_wdata;
    logic                  w_out_free;

    chs_hash u_hash (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_accept),
        .i_point_x (i_point_x),
        .i_point_y (i_point_y),
        .o_hash    (w_hash),
        .o_done    (w_hash_done)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_stride   = {w_hash[HASH_W-1 -: (TABLE_BITS-1)], 1'b1};

    assign w_ins   = (r_cmd == CMD_INSERT);
    assign w_empty = (r_rdata == '0);
    assign w_match = (r_rdata == r_hash);
    assign w_last  = (r_k == '1);
    assign w_store = (r_state == S_CMP) && w_empty && w_ins && (r_hash != '0);
    assign w_drop  = (r_state == S_CMP) && !w_empty && w_match && !w_ins;
    assign w_finish = w_empty || w_match || w_last;

    always_comb begin
        if (w_empty) begin
            w_result = w_ins ? ST_INSERTED : ST_ABSENT;
        end else if (w_match) begin
            w_result = w_ins ? ST_PRESENT : ST_REMOVED;
        end else begin
            w_result = w_ins ? ST_FULL : ST_ABSENT;
        end
    end

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (r_clr_addr == '1) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (w_accept) n_state = S_HASH;
            end
            S_HASH: begin
                if (w_hash_done) n_state = S_RD;
            end
            S_RD: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                n_state = w_finish ? S_DONE : S_RD;
            end
            S_DONE: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (w_store) begin
                r_count <= r_count + 1'b1;
            end else if (w_drop && (r_count != '0)) begin
                r_count <= r_count - 1'b1;
            end
            if ((r_state == S_DONE) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // probe datapath
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_cmd;
        end
        if ((r_state == S_HASH) && w_hash_done) begin
            r_hash   <= w_hash;
            r_stride <= w_stride;
            r_pos    <= w_hash[TABLE_BITS-1:0] + w_stride;
            r_k      <= '0;
        end else if ((r_state == S_CMP) && !w_finish) begin
            r_pos <= r_pos + r_stride;
            r_k   <= r_k + 1'b1;
        end
        if (r_state == S_CMP) begin
            r_result <= w_result;
        end
        if ((r_state == S_DONE) && w_out_free) begin
            r_out_status <= r_result;
            r_out_occ    <= r_count[OCC_W-1:0];
        end
    end

    // slot memory
    assign w_we    = (r_state == S_CLEAR) || w_store || w_drop;
    assign w_waddr = (r_state == S_CLEAR) ? r_clr_addr : r_pos;
    assign w_wdata = w_store ? r_hash : '0;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[r_pos];
    end

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_occupancy = r_out_occ;

`ifndef SYNTHESIS
    a_state_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot(r_state))
        else $error("state register not one-hot");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TABLE_SIZE))
        else $error("occupancy above table size");

    a_accept_hash: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_HASH))
        else $error("accepted item did not start hashing");

    a_count_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_count) |-> $past(r_state == S_CMP))
        else $error("occupancy changed outside compare");
`endif

endmodule

### src/chs_hash.sv
// chs_hash: 64-bit point hash, (packed - offset) * multiplier mod 2^64
// one shared 32x32 multiplier, three partial products in steps LL, LH, HL, FIN; uses chs_pkg
module chs_hash import chs_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic signed [COORD_W-1:0] i_point_x,
    input  logic signed [COORD_W-1:0] i_point_y,
    output logic [HASH_W-1:0]         o_hash,
    output logic                      o_done
);

    localparam logic [1:0] STEP_LL = 2'd0;
    localparam logic [1:0] STEP_LH = 2'd1;
    localparam logic [1:0] STEP_HL = 2'd2;
    localparam logic [1:0] STEP_FIN = 2'd3;

    logic [HASH_W-1:0]  r_opnd;
    logic [HASH_W-1:0]  r_prod;
    logic [HASH_W-1:0]  r_acc;
    logic [1:0]         r_step;
    logic               r_busy;
    logic               r_done;
    logic [COORD_W-1:0] w_mul_a;
    logic [COORD_W-1:0] w_mul_b;
    logic [HASH_W-1:0]  w_prod;

    assign w_mul_a = (r_step == STEP_HL) ? r_opnd[63:32] : r_opnd[31:0];
    assign w_mul_b = (r_step == STEP_LH) ? HASH_MULT[63:32] : HASH_MULT[31:0];
    assign w_prod  = HASH_W'(w_mul_a) * HASH_W'(w_mul_b);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= STEP_LL;
        end else begin
            r_done <= r_busy && (r_step == STEP_FIN);
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_LL;
            end else if (r_busy) begin
                r_step <= r_step + 2'd1;
                if (r_step == STEP_FIN) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_opnd <= {i_point_y, i_point_x} - HASH_OFFSET;
        end else if (r_busy) begin
            r_prod <= w_prod;
            case (r_step)
                STEP_LL: begin
                end
                STEP_LH: begin
                    r_acc <= r_prod;
                end
                default: begin
                    r_acc[63:32] <= r_acc[63:32] + r_prod[31:0];
                end
            endcase
        end
    end

    assign o_hash = r_acc;
    assign o_done = r_done;

endmodule

### test/tb_top.sv
// tb_top: self-checking bench for coordinate_hash_set_core, insert and remove of (x,y) points
// a scoreboard class keeps its own probe table and answer queue; depends on chs_pkg
// stimulus: directed chain and extreme cases, random mix, a fill to full, then full-table work
module tb_top import chs_pkg::*; ();

    localparam int TBITS = TABLE_BITS_DEF;
    localparam int SLOTS = 1 << TBITS;

    typedef struct {
        t_status          status;
        logic [OCC_W-1:0] occupancy;
    } t_point_answer;

    class t_point_set_tracker;
        bit [HASH_W-1:0] slot_hash [SLOTS];
        int unsigned     used_slots;
        int unsigned     mismatches;
        t_point_answer   pending_answers [$];

        function new();
            foreach (slot_hash[i]) slot_hash[i] = '0;
            used_slots = 0;
            mismatches = 0;
        endfunction

        function bit [HASH_W-1:0] point_hash(bit [63:0] pt);
            return (pt - HASH_OFFSET) * HASH_MULT;
        endfunction

        function t_status probe_insert(bit [HASH_W-1:0] h);
            bit [TBITS-1:0] step;
            bit [TBITS-1:0] pos;
            step = h[HASH_W-1 -: TBITS] | 1'b1;
            pos  = h[TBITS-1:0];
            for (int k = 0; k < SLOTS; k++) begin
                pos = pos + step;
                if (slot_hash[pos] == '0) begin
                    // zero hash is answered as inserted but never stored
                    if (h != '0) begin
                        slot_hash[pos] = h;
                        used_slots++;
                    end
                    return ST_INSERTED;
                end
                if (slot_hash[pos] == h) return ST_PRESENT;
            end
            return ST_FULL;
        endfunction

        function t_status probe_remove(bit [HASH_W-1:0] h);
            bit [TBITS-1:0] step;
            bit [TBITS-1:0] pos;
            step = h[HASH_W-1 -: TBITS] | 1'b1;
            pos  = h[TBITS-1:0];
            for (int k = 0; k < SLOTS; k++) begin
                pos = pos + step;
                if (slot_hash[pos] == '0) return ST_ABSENT;
                if (slot_hash[pos] == h) begin
                    // cleared without a tombstone
                    slot_hash[pos] = '0;
                    if (used_slots > 0) used_slots--;
                    return ST_REMOVED;
                end
            end
            return ST_ABSENT;
        endfunction

        function void note_item(logic cmd, bit [63:0] pt);
            t_point_answer   ans;
            bit [HASH_W-1:0] h;
            h = point_hash(pt);
            ans.status    = (cmd == CMD_INSERT) ? probe_insert(h) : probe_remove(h);
            ans.occupancy = OCC_W'(used_slots);
            pending_answers.push_back(ans);
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("mismatch at %0t: %s", $time, what);
        endtask

        task check_result(logic [STATUS_W-1:0] st, logic [OCC_W-1:0] occ);
            t_point_answer ans;
            if (pending_answers.size() == 0) begin
                report_mismatch($sformatf("unexpected result status %0d occupancy %0d",
                                          st, occ));
                return;
            end
            ans = pending_answers.pop_front();
            if (st !== ans.status)
                report_mismatch($sformatf("status %0d, predicted %0d", st, ans.status));
            if (occ !== ans.occupancy)
                report_mismatch($sformatf("occupancy %0d, predicted %0d",
                                          occ, ans.occupancy));
        endtask
    endclass

    logic                      i_clk       = 1'b0;
    logic                      i_rst_n     = 1'b0;
    logic                      i_in_valid  = 1'b0;
    logic                      i_cmd       = CMD_INSERT;
    logic signed [COORD_W-1:0] i_point_x   = '0;
    logic signed [COORD_W-1:0] i_point_y   = '0;
    logic                      i_out_ready = 1'b0;
    logic                      o_in_ready;
    logic                      o_out_valid;
    logic [STATUS_W-1:0]       o_status;
    logic [OCC_W-1:0]          o_occupancy;

    t_point_set_tracker tracker = new();

    logic [63:0]    inv_mult;
    logic [63:0]    inserted_points [$];
    bit [TBITS-1:0] chain_top [2];
    bit [TBITS-1:0] chain_low [2];
    int             burst_left;

    coordinate_hash_set_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_cmd       (i_cmd),
        .i_point_x   (i_point_x),
        .i_point_y   (i_point_y),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_status    (o_status),
        .o_occupancy (o_occupancy)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // point whose hash is h, through the inverse of the multiplier
    function automatic logic [63:0] hash_point(logic [63:0] h);
        return h * inv_mult + HASH_OFFSET;
    endfunction

    // hash on a shared probe chain: same start slot and step for a given pair
    function automatic logic [63:0] chain_point(int sel, logic [63:0] mid);
        logic [63:0] h;
        h = (64'(chain_top[sel]) << (HASH_W - TBITS))
            | ((mid << TBITS) & ~(64'(chain_top[sel]) << (HASH_W - TBITS)))
            | 64'(chain_low[sel]);
        return hash_point(h);
    endfunction

    function automatic logic [63:0] pooled_point();
        return inserted_points[$urandom_range(0, inserted_points.size() - 1)];
    endfunction

    function automatic logic [63:0] fresh_point();
        return {$urandom, $urandom};
    endfunction

    task automatic send_point(logic cmd, logic [63:0] pt);
        int gap;
        i_in_valid <= 1'b1;
        i_cmd      <= cmd;
        i_point_x  <= pt[31:0];
        i_point_y  <= pt[63:32];
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        tracker.note_item(cmd, pt);
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    initial begin
        logic [63:0] pa, pb, pc, pt, zero_pt;
        int          r, guard;
        inv_mult = HASH_MULT;
        repeat (6) inv_mult = inv_mult * (64'd2 - HASH_MULT * inv_mult);
        zero_pt = HASH_OFFSET;
        foreach (chain_top[i]) begin
            chain_top[i] = TBITS'($urandom);
            chain_low[i] = TBITS'($urandom);
        end
        burst_left = $urandom_range(1, 24);
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes, repeats, zero hash
        send_point(CMD_INSERT, 64'h0);
        send_point(CMD_INSERT, 64'h0);
        send_point(CMD_INSERT, {32'h8000_0000, 32'h7fff_ffff});
        send_point(CMD_INSERT, {32'h7fff_ffff, 32'h8000_0000});
        send_point(CMD_INSERT, {32'hffff_ffff, 32'hffff_ffff});
        send_point(CMD_INSERT, {32'h7fff_ffff, 32'h7fff_ffff});
        send_point(CMD_REMOVE, 64'h0);
        send_point(CMD_REMOVE, 64'h0);
        send_point(CMD_INSERT, zero_pt);
        send_point(CMD_REMOVE, zero_pt);

        // one probe chain: removal without tombstone cuts it short
        pa = chain_point(0, 64'd1);
        pb = chain_point(0, 64'd2);
        pc = chain_point(0, 64'd3);
        send_point(CMD_INSERT, pa);
        send_point(CMD_INSERT, pb);
        send_point(CMD_INSERT, pc);
        send_point(CMD_REMOVE, pa);
        send_point(CMD_REMOVE, pb);
        send_point(CMD_INSERT, pb);
        send_point(CMD_REMOVE, pc);
        send_point(CMD_REMOVE, pb);
        send_point(CMD_REMOVE, pb);
        send_point(CMD_REMOVE, {32'h8000_0000, 32'h7fff_ffff});
        send_point(CMD_INSERT, {32'h7fff_ffff, 32'h8000_0000});

        inserted_points.push_back({32'h7fff_ffff, 32'h8000_0000});
        inserted_points.push_back({32'hffff_ffff, 32'hffff_ffff});
        inserted_points.push_back(pb);

        // random mix at low load
        repeat (300) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                pt = fresh_point();
                inserted_points.push_back(pt);
                send_point(CMD_INSERT, pt);
            end else if (r < 65) begin
                send_point(CMD_INSERT, pooled_point());
            end else if (r < 85) begin
                send_point(CMD_REMOVE, pooled_point());
            end else if (r < 91) begin
                send_point(CMD_REMOVE, fresh_point());
            end else if (r < 94) begin
                send_point(logic'($urandom_range(0, 1)), zero_pt);
            end else begin
                send_point(logic'($urandom_range(0, 1)),
                           chain_point($urandom_range(0, 1), 64'($urandom_range(1, 6))));
            end
        end

        // fill the table
        guard = 0;
        while (tracker.used_slots < SLOTS && guard < 4000) begin
            guard++;
            r = $urandom_range(0, 99);
            if (r < 90) begin
                pt = fresh_point();
                inserted_points.push_back(pt);
                send_point(CMD_INSERT, pt);
            end else if (r < 95) begin
                send_point(CMD_INSERT, pooled_point());
            end else begin
                send_point(CMD_REMOVE, pooled_point());
            end
        end

        // full table: whole-table probes, refills after removal
        repeat (40) begin
            case ($urandom_range(0, 5))
                0: begin
                    pt = fresh_point();
                    inserted_points.push_back(pt);
                    send_point(CMD_INSERT, pt);
                end
                1: send_point(CMD_INSERT, pooled_point());
                2: send_point(CMD_REMOVE, fresh_point());
                3: send_point(CMD_INSERT, zero_pt);
                default: send_point(CMD_REMOVE, pooled_point());
            endcase
        end

        i_in_valid <= 1'b0;
        guard = 0;
        while (tracker.pending_answers.size() != 0 && guard < 20000) begin
            guard++;
            @(posedge i_clk);
        end
        repeat (20) @(posedge i_clk);
        if (tracker.pending_answers.size() != 0)
            tracker.report_mismatch($sformatf("%0d results never arrived",
                                              tracker.pending_answers.size()));
        if (tracker.mismatches == 0) begin
            $display("coordinate_hash_set_core verification clean");
        end else begin
            $display("coordinate_hash_set_core verification failed");
        end
        $finish;
    end

    // receiver: ready pattern switches among always ready, random and sparse, one long hold-off
    initial begin
        int  cyc;
        int  mode;
        logic rdy;
        cyc  = 0;
        mode = 0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (cyc % 64 == 0) mode = $urandom_range(0, 2);
            if (cyc >= 4000 && cyc < 4500) begin
                rdy = 1'b0;
            end else begin
                case (mode)
                    0:       rdy = 1'b1;
                    1:       rdy = logic'($urandom_range(0, 1));
                    default: rdy = (cyc % 4 == 0);
                endcase
            end
            i_out_ready <= rdy;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            tracker.check_result(o_status, o_occupancy);
    end

    initial begin
        #20000000;
        $display("coordinate_hash_set_core verification failed");
        $finish;
    end

endmodule
